@@ rtl/smou_pkg.sv @@
// Shared types, codes and helpers for the stack machine operation unit.
package smou_pkg;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int CHAR_W      = 8;
  localparam int DEPTH_OUT_W = 6;
  localparam int QUEUE_DEPTH = 2;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PCHAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PSTR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ROTR  = 3'd5;

  // Printable window and line end
  localparam logic [DATA_W-1:0] CHAR_LO = 32'd32;
  localparam logic [DATA_W-1:0] CHAR_HI = 32'd126;
  localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_RANGE   = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_MOD,
    OP_PCHAR,
    OP_PSTR,
    OP_ROTL,
    OP_ROTR,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MOD_B,
    BS_MOD_A,
    BS_MOD_WAIT,
    BS_PC_CHK,
    BS_PC_EMIT,
    BS_PS_CHK,
    BS_NL,
    BS_ROT_WR,
    BS_FIN
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic printable(input logic [DATA_W-1:0] w);
    return (w >= CHAR_LO) && (w <= CHAR_HI);
  endfunction

endpackage

@@ rtl/smou_ifs.sv @@
// Valid/ready channel interfaces for the command and result words.
interface smou_in_if;
  logic                             valid;
  logic                             ready;
  logic [smou_pkg::CMD_W-1:0]       cmd;
  logic signed [smou_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface smou_out_if;
  logic                               valid;
  logic                               ready;
  logic [smou_pkg::STATUS_W-1:0]      status;
  logic                               has_char;
  logic [smou_pkg::CHAR_W-1:0]        char_code;
  logic                               last;
  logic [smou_pkg::DEPTH_OUT_W-1:0]   depth_now;

  modport source (output valid, output status, output has_char, output char_code,
                  output last, output depth_now, input ready);
  modport sink   (input valid, input status, input has_char, input char_code,
                  input last, input depth_now, output ready);
endinterface

@@ rtl/smou_front.sv @@
// Front end: accept command words, decode them and queue them for the back end.
module smou_front (
  input  logic                 clk,
  input  logic                 rst_n,
  smou_in_if.sink              in_ch,
  output smou_pkg::q_item_t    q_item,
  output logic                 q_valid,
  input  logic                 q_ready
);

  localparam int QPW = $clog2(smou_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(smou_pkg::QUEUE_DEPTH + 1);

  smou_pkg::q_item_t q_mem_r [smou_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]    wp_r, wp_nxt;
  logic [QPW-1:0]    rp_r, rp_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              push, pop;
  smou_pkg::q_item_t in_item;

  // Decode the raw command into an operation class
  function automatic smou_pkg::op_t classify(input logic [smou_pkg::CMD_W-1:0] c);
    smou_pkg::op_t o;
    case (c)
      smou_pkg::CMD_PUSH:  o = smou_pkg::OP_PUSH;
      smou_pkg::CMD_MOD:   o = smou_pkg::OP_MOD;
      smou_pkg::CMD_PCHAR: o = smou_pkg::OP_PCHAR;
      smou_pkg::CMD_PSTR:  o = smou_pkg::OP_PSTR;
      smou_pkg::CMD_ROTL:  o = smou_pkg::OP_ROTL;
      smou_pkg::CMD_ROTR:  o = smou_pkg::OP_ROTR;
      default:             o = smou_pkg::OP_NOP;
    endcase
    return o;
  endfunction

  assign in_ch.ready = (cnt_r != QCW'(smou_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = q_mem_r[rp_r];

  always_comb begin
    in_item.op    = classify(in_ch.cmd);
    in_item.value = in_ch.push_value;
  end

  // Advance queue pointers
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPW'(smou_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + QPW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QPW'(smou_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + QPW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= in_item;
    end
  end

endmodule

@@ rtl/smou_div.sv @@
// Iterative signed remainder unit, one quotient bit per cycle, C truncation.
module smou_div (
  input  logic                clk,
  input  logic                rst_n,
  input  smou_pkg::div_req_t  req,
  output smou_pkg::div_rsp_t  rsp
);

  localparam int W  = smou_pkg::DATA_W;
  localparam int KW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // Shift in one dividend bit and try the subtraction
  assign shifted = {rem_r, dvd_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      // Load magnitudes; the remainder takes the dividend's sign
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend[W-1] ? (~req.dividend + W'(1)) : req.dividend;
      dvs_nxt  = req.divisor[W-1] ? (~req.divisor + W'(1)) : req.divisor;
      neg_nxt  = req.dividend[W-1];
    end else if (busy_r) begin
      rem_nxt = diff[W] ? shifted[W-1:0] : diff[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + KW'(1);
      if (cnt_r == KW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Apply the sign on the way out
  always_comb begin
    rsp.done      = done_r;
    rsp.remainder = neg_r ? (~rem_r + W'(1)) : rem_r;
  end

endmodule

@@ rtl/smou_back.sv @@
// Back end: stack memory, operation sequencer and result output register.
module smou_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smou_pkg::q_item_t   q_item,
  input  logic                q_valid,
  output logic                q_ready,
  output smou_pkg::div_req_t  div_req,
  input  smou_pkg::div_rsp_t  div_rsp,
  smou_out_if.source          out_ch
);

  localparam int PW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W  = smou_pkg::DATA_W;

  smou_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         base_r, base_nxt;
  logic [PW-1:0]         idx_r, idx_nxt;
  smou_pkg::op_t         op_r, op_nxt;
  smou_pkg::status_t     status_r, status_nxt;
  logic [smou_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic [W-1:0]          b_r, b_nxt;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rd_data_r;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_wa, mem_ra;
  logic [W-1:0]  mem_wd;

  logic                        out_valid_r;
  smou_pkg::status_t           out_status_r;
  logic                        out_has_r;
  logic [smou_pkg::CHAR_W-1:0] out_char_r;
  logic                        out_last_r;
  logic [smou_pkg::DEPTH_OUT_W-1:0] out_depth_r;

  logic                        out_free;
  logic                        emit;
  smou_pkg::status_t           e_status;
  logic                        e_has;
  logic [smou_pkg::CHAR_W-1:0] e_char;
  logic                        e_last;

  // Map a logical stack position onto the circular buffer
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(STACK_DEPTH)) begin
      sum = sum - (CW+1)'(STACK_DEPTH);
    end
    return PW'(sum);
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequence one operation at a time
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    char_nxt   = char_r;
    b_nxt      = b_r;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    div_req    = '0;
    emit       = 1'b0;
    e_status   = smou_pkg::ST_OK;
    e_has      = 1'b0;
    e_char     = '0;
    e_last     = 1'b0;

    case (state_r)
      smou_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_ready    = 1'b1;
          op_nxt     = q_item.op;
          status_nxt = smou_pkg::ST_OK;
          state_nxt  = smou_pkg::BS_FIN;
          case (q_item.op)
            smou_pkg::OP_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                status_nxt = smou_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = phys(base_r, count_r);
                mem_wd    = q_item.value;
                count_nxt = count_r + CW'(1);
              end
            end
            smou_pkg::OP_MOD: begin
              if (count_r < CW'(2)) begin
                status_nxt = smou_pkg::ST_SHORT;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = phys(base_r, count_r - CW'(1));
                state_nxt = smou_pkg::BS_MOD_B;
              end
            end
            smou_pkg::OP_PCHAR: begin
              if (count_r == '0) begin
                status_nxt = smou_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = phys(base_r, count_r - CW'(1));
                state_nxt = smou_pkg::BS_PC_CHK;
              end
            end
            smou_pkg::OP_PSTR: begin
              if (count_r == '0) begin
                state_nxt = smou_pkg::BS_NL;
              end else begin
                idx_nxt   = PW'(count_r - CW'(1));
                mem_re    = 1'b1;
                mem_ra    = phys(base_r, count_r - CW'(1));
                state_nxt = smou_pkg::BS_PS_CHK;
              end
            end
            smou_pkg::OP_ROTL: begin
              if (count_r >= CW'(2)) begin
                mem_re    = 1'b1;
                mem_ra    = phys(base_r, count_r - CW'(1));
                state_nxt = smou_pkg::BS_ROT_WR;
              end
            end
            smou_pkg::OP_ROTR: begin
              if (count_r >= CW'(2)) begin
                mem_re    = 1'b1;
                mem_ra    = base_r;
                state_nxt = smou_pkg::BS_ROT_WR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      smou_pkg::BS_MOD_B: begin
        // Top word is the divisor
        b_nxt = rd_data_r;
        if (rd_data_r == '0) begin
          status_nxt = smou_pkg::ST_DIVZERO;
          state_nxt  = smou_pkg::BS_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = phys(base_r, count_r - CW'(2));
          state_nxt = smou_pkg::BS_MOD_A;
        end
      end

      smou_pkg::BS_MOD_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = rd_data_r;
        div_req.divisor  = b_r;
        state_nxt        = smou_pkg::BS_MOD_WAIT;
      end

      smou_pkg::BS_MOD_WAIT: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wa    = phys(base_r, count_r - CW'(2));
          mem_wd    = div_rsp.remainder;
          count_nxt = count_r - CW'(1);
          state_nxt = smou_pkg::BS_FIN;
        end
      end

      smou_pkg::BS_PC_CHK: begin
        if (!smou_pkg::printable(rd_data_r)) begin
          status_nxt = smou_pkg::ST_RANGE;
          state_nxt  = smou_pkg::BS_FIN;
        end else begin
          char_nxt  = rd_data_r[smou_pkg::CHAR_W-1:0];
          state_nxt = smou_pkg::BS_PC_EMIT;
        end
      end

      smou_pkg::BS_PC_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_has     = 1'b1;
          e_char    = char_r;
          state_nxt = smou_pkg::BS_NL;
        end
      end

      smou_pkg::BS_PS_CHK: begin
        // Walk down while the words stay printable; read ahead on each emit
        if (smou_pkg::printable(rd_data_r)) begin
          if (out_free) begin
            emit   = 1'b1;
            e_has  = 1'b1;
            e_char = rd_data_r[smou_pkg::CHAR_W-1:0];
            if (idx_r == '0) begin
              state_nxt = smou_pkg::BS_NL;
            end else begin
              idx_nxt = idx_r - PW'(1);
              mem_re  = 1'b1;
              mem_ra  = phys(base_r, CW'(idx_r - PW'(1)));
            end
          end
        end else begin
          state_nxt = smou_pkg::BS_NL;
        end
      end

      smou_pkg::BS_NL: begin
        if (out_free) begin
          emit      = 1'b1;
          e_has     = 1'b1;
          e_char    = smou_pkg::CHAR_NL;
          e_last    = 1'b1;
          state_nxt = smou_pkg::BS_IDLE;
        end
      end

      smou_pkg::BS_ROT_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_data_r;
        if (op_r == smou_pkg::OP_ROTL) begin
          // Old top becomes the slot below the bottom
          base_nxt = (base_r == '0) ? PW'(STACK_DEPTH - 1) : base_r - PW'(1);
          mem_wa   = base_nxt;
        end else begin
          // Old bottom becomes the slot above the top
          mem_wa   = phys(base_r, count_r);
          base_nxt = phys(base_r, CW'(1));
        end
        state_nxt = smou_pkg::BS_FIN;
      end

      smou_pkg::BS_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          e_status  = status_r;
          e_last    = 1'b1;
          state_nxt = smou_pkg::BS_IDLE;
        end
      end

      default: begin
        state_nxt = smou_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smou_pkg::BS_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      base_r  <= base_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold per-operation working values
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    char_r   <= char_nxt;
    b_r      <= b_nxt;
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_has_r    <= e_has;
      out_char_r   <= e_char;
      out_last_r   <= e_last;
      out_depth_r  <= smou_pkg::DEPTH_OUT_W'(count_r);
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.has_char  = out_has_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.depth_now = out_depth_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> (count_r == $past(count_r) + CW'(1)) ||
                          (count_r == $past(count_r) - CW'(1)))
    else $error("stack count moved by more than one");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == smou_pkg::BS_MOD_WAIT)
    else $error("remainder ready outside mod wait");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> (state_r == smou_pkg::BS_IDLE) && q_valid)
    else $error("queue popped while busy");

endmodule

@@ rtl/stack_machine_op_unit.sv @@
// Stack machine operation unit: top level joining front end, back end and divider.
//
// Keeps a bounded stack of signed 32-bit words and runs one opcode per command
// word (push, mod, pchar, pstr, rotl, rotr). A two-entry queue sits between the
// decoding front end and the executing back end, and results leave through an
// output register, so commands are taken while earlier results wait. The stack
// lives in a single-port-write, registered-read memory used as a circular
// buffer, so rotations cost one read and one write. Push, mod on fewer than two
// words, pchar or pstr on an empty stack, rotations below two words and unknown
// codes go straight to the result word; mod by zero, pchar out of range and
// rotations first read the stack; pchar emits its character before the newline;
// pstr emits one character a cycle while the result side is ready, until the
// stack bottom or a zero or non-printable word ends the walk; mod waits for the
// divider, which produces one quotient bit a cycle. The back end takes the next
// queued word in the cycle after it loads the last result word of the previous
// one. No clearing pass is needed after reset.
module stack_machine_op_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  smou_in_if.sink     in_ch,
  smou_out_if.source  out_ch
);

  smou_pkg::q_item_t  q_item;
  logic               q_valid;
  logic               q_ready;
  smou_pkg::div_req_t div_req;
  smou_pkg::div_rsp_t div_rsp;

  smou_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  smou_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  smou_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule
